// File: sv/cplp_pkg.sv
// Shared types, codes and character constants for the coordinate pair line parser.
`default_nettype none

package cplp_pkg;

   localparam int unsigned CPLP_COORD_BITS = 16;
   localparam int unsigned CPLP_OUT_BITS   = 16;
   localparam int unsigned CPLP_CHAR_BITS  = 8;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_LEAD  = 3'd0,
      PH_X     = 3'd1,
      PH_GAP   = 3'd2,
      PH_Y     = 3'd3,
      PH_TRAIL = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_VALID     = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic [CPLP_OUT_BITS-1:0]   coord_x;
      logic [CPLP_OUT_BITS-1:0]   coord_y;
   } result_type;

endpackage

`default_nettype wire

// File: sv/cplp_line_state.sv
// Per-line parse state, its next-state logic and the line result.
`default_nettype none

module cplp_line_state
   import cplp_pkg::*;
#(
   parameter int unsigned COORD_BITS = CPLP_COORD_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [CPLP_CHAR_BITS-1:0] char_code,
   input  wire logic                      line_end,
   output result_type                     result
);

   phase_type             phase_ff, phase_in;
   logic [COORD_BITS-1:0] x_acc_ff, x_acc_in;
   logic [COORD_BITS-1:0] y_acc_ff, y_acc_in;
   logic                  bad_ff, bad_in;
   logic                  struct_err_ff, struct_err_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic                  ovf_ff, ovf_in;

   logic                  is_digit;
   logic                  is_blank;
   logic                  is_comma;
   logic [3:0]            digit;
   logic                  use_x;
   logic [COORD_BITS-1:0] acc_sel;
   logic [COORD_BITS+3:0] acc_next;
   logic                  acc_ovf;
   logic                  final_struct_err;
   status_type            status;
   logic [COORD_BITS+CPLP_OUT_BITS-1:0] x_wide;
   logic [COORD_BITS+CPLP_OUT_BITS-1:0] y_wide;

   assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                     (char_code == CH_CR) || (char_code == CH_LF);
   assign is_comma = (char_code == CH_COMMA);
   assign digit    = 4'(char_code - CH_ZERO);

   assign use_x    = (phase_ff == PH_LEAD) || (phase_ff == PH_X);
   assign acc_sel  = use_x ? x_acc_ff : y_acc_ff;
   assign acc_next = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} +
                     {{COORD_BITS{1'b0}}, digit};
   assign acc_ovf  = |acc_next[COORD_BITS+3:COORD_BITS];

   always_comb begin
      phase_in      = phase_ff;
      x_acc_in      = x_acc_ff;
      y_acc_in      = y_acc_ff;
      bad_in        = bad_ff;
      struct_err_in = struct_err_ff;
      digit_seen_in = digit_seen_ff;
      ovf_in        = ovf_ff;

      if (is_digit) begin
         digit_seen_in = 1'b1;
         case (phase_ff) inside
            PH_LEAD, PH_X, PH_GAP, PH_Y: begin
               if (phase_ff == PH_LEAD) begin
                  phase_in = PH_X;
               end else if (phase_ff == PH_GAP) begin
                  phase_in = PH_Y;
               end
               if (acc_ovf) begin
                  ovf_in = 1'b1;
               end else if (use_x) begin
                  x_acc_in = acc_next[COORD_BITS-1:0];
               end else begin
                  y_acc_in = acc_next[COORD_BITS-1:0];
               end
            end
            default: begin
               struct_err_in = 1'b1;
            end
         endcase
      end else if (is_blank) begin
         if (phase_ff == PH_X) begin
            struct_err_in = 1'b1;
         end else if (phase_ff == PH_Y) begin
            phase_in = PH_TRAIL;
         end
      end else if (is_comma) begin
         if (phase_ff == PH_X) begin
            phase_in = PH_GAP;
         end else begin
            struct_err_in = 1'b1;
         end
      end else begin
         bad_in = 1'b1;
      end

      final_struct_err = struct_err_in ||
                         !((phase_in == PH_Y) || (phase_in == PH_TRAIL));

      if (bad_in) begin
         status = ST_MALFORMED;
      end else if (!digit_seen_in) begin
         status = ST_EMPTY;
      end else if (final_struct_err) begin
         status = ST_MALFORMED;
      end else if (ovf_in) begin
         status = ST_OVERFLOW;
      end else begin
         status = ST_VALID;
      end

      x_wide = {{CPLP_OUT_BITS{1'b0}}, x_acc_in};
      y_wide = {{CPLP_OUT_BITS{1'b0}}, y_acc_in};

      result.status  = status;
      result.coord_x = (status == ST_VALID) ? x_wide[CPLP_OUT_BITS-1:0] : '0;
      result.coord_y = (status == ST_VALID) ? y_wide[CPLP_OUT_BITS-1:0] : '0;

      // drop all line state once the last character is taken
      if (line_end) begin
         phase_in      = PH_LEAD;
         x_acc_in      = '0;
         y_acc_in      = '0;
         bad_in        = 1'b0;
         struct_err_in = 1'b0;
         digit_seen_in = 1'b0;
         ovf_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         x_acc_ff      <= '0;
         y_acc_ff      <= '0;
         bad_ff        <= 1'b0;
         struct_err_ff <= 1'b0;
         digit_seen_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         x_acc_ff      <= x_acc_in;
         y_acc_ff      <= y_acc_in;
         bad_ff        <= bad_in;
         struct_err_ff <= struct_err_in;
         digit_seen_ff <= digit_seen_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/coordinate_pair_line_parser_unit.sv
// Top level: input word register, line parse state and result register.
// A line's result enters the result register, which drives rsp, as its last word
// leaves the input word register. Throughput: one word per cycle unless stalled.
// A result waiting in the output register stalls only a following last word.
// Synchronous active-high reset clears the parse state and both valid flags.
`default_nettype none

module coordinate_pair_line_parser_unit
   import cplp_pkg::*;
#(
   parameter int unsigned COORD_BITS = CPLP_COORD_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // line_end
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [15:0] coord_x, [31:16] coord_y
   output      logic [1:0]  rsp_tuser    // [1:0] status
);

   logic                      in_valid_ff, in_valid_in;
   logic [CPLP_CHAR_BITS-1:0] char_ff;
   logic                      last_ff;
   logic                      advance;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                result;
   result_type                rsp_ff;

   assign advance     = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_comb begin
      if (advance && last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (advance && last_ff) begin
         rsp_ff <= result;
      end
   end

   cplp_line_state #(
      .COORD_BITS (COORD_BITS)
   ) u_line_state (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (char_ff),
      .line_end  (last_ff),
      .result    (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.coord_y, rsp_ff.coord_x};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire
